/* hw/rtl/mpn_pkg.sv */
// mpn_pkg: shared constants, register indexes and the box record for the
// non-overlapping max pooling stream; used by every module but mpn_ram
package mpn_pkg;

    localparam int MAX_COLS    = 1024;
    localparam int SAMPLE_BITS = 16;
    localparam int VAL_W       = SAMPLE_BITS - 1;
    localparam int COL_W       = $clog2(MAX_COLS);
    localparam int ROW_W       = 10;
    localparam int DIM_W       = 11;
    localparam int BOX_W       = 7;
    localparam int OFF_W       = 6;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 11;

    localparam logic [DIM_W-1:0] DIM_MAX = 11'd1024;
    localparam logic [BOX_W-1:0] BOX_MAX = 7'd64;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_ROWS  = 3'd0,
        REG_FRAME_COLS  = 3'd1,
        REG_BOX_ROWS    = 3'd2,
        REG_BOX_COLS    = 3'd3,
        REG_LAYER_COUNT = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic             wr;
        logic             emit;
        logic             use_line;
        logic             eol;
        logic             eot;
        logic [VAL_W-1:0] m;
        logic [COL_W-1:0] addr;
    } t_box_info;

endpackage

/* hw/rtl/mpn_ram.sv */
// mpn_ram: generic single-port-write, single-port-read RAM with registered read
// no package dependency
module mpn_ram #(
    parameter int WIDTH = 15,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/mpn_ctrl.sv */
// mpn_ctrl: configuration registers, raster position counters and running
// maximum; depends on mpn_pkg
module mpn_ctrl
    import mpn_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_accept,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    output t_box_info             o_info
);

    logic [DIM_W-1:0] r_rows, r_cols, r_layers;
    logic [BOX_W-1:0] r_brows, r_bcols;
    logic [COL_W-1:0] r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;
    logic [OFF_W-1:0] r_offc, n_offc;
    logic [OFF_W-1:0] r_offr, n_offr;
    logic [COL_W-1:0] r_oc, n_oc;
    logic [ROW_W-1:0] r_layer, n_layer;
    logic [VAL_W-1:0] r_rmax, n_rmax;

    logic [DIM_W-1:0] dim_val;
    logic [BOX_W-1:0] box_val;
    logic [VAL_W-1:0] v, rmax_new;
    logic [11:0]      col_box_end, row_box_end;
    logic [DIM_W-1:0] col_next, row_next, layer_next;
    logic [BOX_W-1:0] offc_next, offr_next;
    logic             valid_col, valid_row, in_box, box_end, row_end;

    always_comb begin
        dim_val = i_cfg_data;
        if (i_cfg_data == '0) begin
            dim_val = DIM_W'(1);
        end else if (i_cfg_data > DIM_MAX) begin
            dim_val = DIM_MAX;
        end
        box_val = i_cfg_data[BOX_W-1:0];
        if (i_cfg_data[BOX_W-1:0] == '0) begin
            box_val = BOX_W'(1);
        end else if (i_cfg_data[BOX_W-1:0] > BOX_MAX) begin
            box_val = BOX_MAX;
        end
    end

    always_comb begin
        v           = i_sample[SAMPLE_BITS-1] ? '0 : i_sample[VAL_W-1:0];
        rmax_new    = (v > r_rmax) ? v : r_rmax;
        col_box_end = 12'(r_col) - 12'(r_offc) + 12'(r_bcols);
        row_box_end = 12'(r_row) - 12'(r_offr) + 12'(r_brows);
        valid_col   = col_box_end <= 12'(r_cols);
        valid_row   = row_box_end <= 12'(r_rows);
        in_box      = valid_col && valid_row;
        offc_next   = BOX_W'(r_offc) + BOX_W'(1);
        offr_next   = BOX_W'(r_offr) + BOX_W'(1);
        col_next    = DIM_W'(r_col) + DIM_W'(1);
        row_next    = DIM_W'(r_row) + DIM_W'(1);
        layer_next  = DIM_W'(r_layer) + DIM_W'(1);
        box_end     = in_box && (offc_next >= r_bcols);
        row_end     = col_next >= r_cols;

        o_info.wr       = box_end;
        o_info.emit     = box_end && (offr_next >= r_brows);
        o_info.use_line = r_offr != '0;
        o_info.eol      = (12'(col_next) + 12'(r_bcols) > 12'(r_cols))
                       && (12'(row_next) + 12'(r_brows) > 12'(r_rows));
        o_info.eot      = o_info.eol && (layer_next >= r_layers);
        o_info.m        = rmax_new;
        o_info.addr     = r_oc;
    end

    always_comb begin
        n_col   = r_col;
        n_row   = r_row;
        n_offc  = r_offc;
        n_offr  = r_offr;
        n_oc    = r_oc;
        n_layer = r_layer;
        n_rmax  = r_rmax;
        if (in_box) begin
            if (box_end) begin
                n_rmax = '0;
                n_offc = '0;
                n_oc   = r_oc + COL_W'(1);
            end else begin
                n_rmax = rmax_new;
                n_offc = offc_next[OFF_W-1:0];
            end
        end
        n_col = col_next[COL_W-1:0];
        if (row_end) begin
            n_col  = '0;
            n_offc = '0;
            n_oc   = '0;
            n_rmax = '0;
            n_offr = (offr_next >= r_brows) ? '0 : offr_next[OFF_W-1:0];
            n_row  = row_next[ROW_W-1:0];
            if (row_next >= r_rows) begin
                n_row   = '0;
                n_offr  = '0;
                n_layer = (layer_next >= r_layers) ? '0 : layer_next[ROW_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows   <= DIM_W'(1);
            r_cols   <= DIM_W'(1);
            r_brows  <= BOX_W'(1);
            r_bcols  <= BOX_W'(1);
            r_layers <= DIM_W'(1);
            r_col    <= '0;
            r_row    <= '0;
            r_offc   <= '0;
            r_offr   <= '0;
            r_oc     <= '0;
            r_layer  <= '0;
            r_rmax   <= '0;
        end else if (i_cfg_we && (i_cfg_index <= REG_LAYER_COUNT)) begin
            unique case (i_cfg_index)
                REG_FRAME_ROWS:  r_rows   <= dim_val;
                REG_FRAME_COLS:  r_cols   <= dim_val;
                REG_BOX_ROWS:    r_brows  <= box_val;
                REG_BOX_COLS:    r_bcols  <= box_val;
                default:         r_layers <= dim_val;
            endcase
            r_col   <= '0;
            r_row   <= '0;
            r_offc  <= '0;
            r_offr  <= '0;
            r_oc    <= '0;
            r_layer <= '0;
            r_rmax  <= '0;
        end else if (i_accept) begin
            r_col   <= n_col;
            r_row   <= n_row;
            r_offc  <= n_offc;
            r_offr  <= n_offr;
            r_oc    <= n_oc;
            r_layer <= n_layer;
            r_rmax  <= n_rmax;
        end
    end

`ifndef NO_ASSERTIONS
    a_col_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        DIM_W'(r_col) < r_cols)
        else $error("column counter beyond frame width");
    a_offr_in_box: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        BOX_W'(r_offr) < r_brows)
        else $error("row offset beyond box height");
    a_offc_in_box: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        BOX_W'(r_offc) < r_bcols)
        else $error("column offset beyond box width");
`endif

endmodule

/* hw/rtl/mpn_merge.sv */
// mpn_merge: merges the box maximum with the line store entry, forwards a
// same-address write, and holds the result register; depends on mpn_pkg
module mpn_merge
    import mpn_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  t_box_info        i_info,
    input  logic [VAL_W-1:0] i_line_data,
    input  logic             i_out_stall,
    output logic             o_free,
    output logic             o_ram_we,
    output logic [COL_W-1:0] o_ram_waddr,
    output logic [VAL_W-1:0] o_ram_wdata,
    output logic             o_out_valid,
    output logic [VAL_W-1:0] o_pooled_value,
    output logic             o_end_of_layer,
    output logic             o_end_of_tensor
);

    t_box_info        r_s1;
    logic             r_s1_valid;
    logic             r_fwd;
    logic [VAL_W-1:0] r_fwd_data;
    logic             r_o_valid;
    logic [VAL_W-1:0] r_o_value;
    logic             r_o_eol, r_o_eot;

    logic [VAL_W-1:0] line, merged;
    logic             out_free, s1_adv;

    always_comb begin
        line     = r_fwd ? r_fwd_data : i_line_data;
        merged   = (r_s1.use_line && (line > r_s1.m)) ? line : r_s1.m;
        out_free = !r_o_valid || !i_out_stall;
        o_free   = !r_s1_valid || !r_s1.emit || out_free;
        s1_adv   = r_s1_valid && o_free;
    end

    assign o_ram_we    = s1_adv && r_s1.wr;
    assign o_ram_waddr = r_s1.addr;
    assign o_ram_wdata = merged;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (i_accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv && r_s1.emit) begin
                r_o_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_s1       <= i_info;
            r_fwd      <= o_ram_we && (i_info.addr == r_s1.addr);
            r_fwd_data <= merged;
        end
        if (s1_adv && r_s1.emit) begin
            r_o_value <= merged;
            r_o_eol   <= r_s1.eol;
            r_o_eot   <= r_s1.eot;
        end
    end

    assign o_out_valid     = r_o_valid;
    assign o_pooled_value  = r_o_value;
    assign o_end_of_layer  = r_o_eol;
    assign o_end_of_tensor = r_o_eot;

`ifndef NO_ASSERTIONS
    a_eot_has_eol: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid |-> (!r_o_eot || r_o_eol))
        else $error("end of tensor without end of layer");
    a_accept_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept |=> r_s1_valid)
        else $error("accepted item missing from merge stage");
    a_write_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ram_we |-> r_s1_valid)
        else $error("line store written without an item");
    a_accept_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && r_s1_valid) |-> s1_adv)
        else $error("merge stage overwritten while held");
`endif

endmodule

/* hw/rtl/max_pool_nonoverlap_stream.sv */
// max_pool_nonoverlap_stream: top level of the streaming max pooling block
// depends on mpn_pkg, mpn_ctrl, mpn_ram and mpn_merge
//
// Takes one sample per clock in raster order while not stalled and gives one
// pooled value per whole box, max(0, box samples), registered first in the
// merge stage and then in the result register; partial boxes at the right
// and bottom edges are dropped. The throughput of one sample per cycle is
// held by the single line store of 1024 partial maxima, read once and
// written once per cycle, with a same-address write forwarded. The input is
// stalled only while a finished box waits behind a result held by the output
// stall. The line store is not cleared after reset; each box row's first row
// writes every entry in use before it is merged. Any configuration write
// restarts the tensor, if its index is 0 to 4, and must be made while idle.
module max_pool_nonoverlap_stream
    import mpn_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [CFG_DATA_W-1:0]         i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [VAL_W-1:0]              o_pooled_value,
    output logic                          o_end_of_layer,
    output logic                          o_end_of_tensor
);

    t_box_info        info;
    logic             accept, free;
    logic             ram_we;
    logic [COL_W-1:0] ram_waddr;
    logic [VAL_W-1:0] ram_wdata, ram_rdata;

    assign accept     = i_in_valid && free;
    assign o_in_stall = !free;

    mpn_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_sample    (i_sample),
        .o_info      (info)
    );

    mpn_ram #(
        .WIDTH (VAL_W),
        .DEPTH (MAX_COLS)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (accept),
        .i_raddr (info.addr),
        .o_rdata (ram_rdata)
    );

    mpn_merge u_merge (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (accept),
        .i_info          (info),
        .i_line_data     (ram_rdata),
        .i_out_stall     (i_out_stall),
        .o_free          (free),
        .o_ram_we        (ram_we),
        .o_ram_waddr     (ram_waddr),
        .o_ram_wdata     (ram_wdata),
        .o_out_valid     (o_out_valid),
        .o_pooled_value  (o_pooled_value),
        .o_end_of_layer  (o_end_of_layer),
        .o_end_of_tensor (o_end_of_tensor)
    );

endmodule
